// ===== rtl/ple_pkg.sv =====
// Package for the positional list engine: sizes, request and status codes,
// cell operations and the command word that is broadcast along the cell row.
// Depends on nothing; every other file refers to it by scoped names.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int REQ_W    = 3;
    localparam int POS_W    = 8;
    localparam int OIDX_W   = 6;
    localparam int OLEN_W   = 7;
    localparam int STAT_W   = 2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_APPEND     = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_UPDATE     = 3'd3,
        REQ_DELETE     = 3'd4,
        REQ_DUMP       = 3'd5
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_WRITE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } ple_state_t;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        cell_op_t          op;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        data_t             value;
    } cell_cmd_t;

endpackage

// ===== rtl/ple_req_if.sv =====
// Request channel of the positional list engine: valid/ready plus payload.
// Depends on ple_pkg for the field widths.
interface ple_req_if;
    logic                           valid;
    logic                           ready;
    logic [ple_pkg::REQ_W-1:0]      req_type;
    logic [ple_pkg::POS_W-1:0]      position;
    logic signed [ple_pkg::DATA_W-1:0] item_value;

    modport source (output valid, req_type, position, item_value, input ready);
    modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

// ===== rtl/ple_res_if.sv =====
// Result channel of the positional list engine: valid/ready plus payload.
// Depends on ple_pkg for the field widths.
interface ple_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [ple_pkg::DATA_W-1:0] out_value;
    logic [ple_pkg::OIDX_W-1:0]        out_index;
    logic [ple_pkg::STAT_W-1:0]        status;
    logic                              last;
    logic [ple_pkg::OLEN_W-1:0]        list_length;

    modport source (output valid, out_value, out_index, status, last, list_length,
                    input ready);
    modport sink   (input valid, out_value, out_index, status, last, list_length,
                    output ready);
endinterface

// ===== rtl/ple_cell.sv =====
// One storage cell of the list row: holds one element and chooses its next
// value from itself, its neighbors, the list head or the request value.
// Depends on ple_pkg.
module ple_cell (
    input  logic                      clk,
    input  logic [ple_pkg::LEN_W-1:0] index,
    input  ple_pkg::cell_cmd_t        cmd,
    input  ple_pkg::data_t            left_val,
    input  ple_pkg::data_t            right_val,
    input  ple_pkg::data_t            head_val,
    output ple_pkg::data_t            value
);

    ple_pkg::data_t            value_reg;
    ple_pkg::data_t            value_next;
    logic [ple_pkg::LEN_W-1:0] index_inc;

    assign index_inc = index + 1'b1;
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            ple_pkg::OP_HOLD:
            begin
                value_next = value_reg;
            end
            ple_pkg::OP_INSERT:
            begin
                if (index > cmd.pos)
                    value_next = left_val;
                else if (index == cmd.pos)
                    value_next = cmd.value;
            end
            ple_pkg::OP_DELETE:
            begin
                if (index >= cmd.pos)
                    value_next = right_val;
            end
            ple_pkg::OP_WRITE:
            begin
                if (index == cmd.pos)
                    value_next = cmd.value;
            end
            ple_pkg::OP_ROTATE:
            begin
                // The occupied part of the row turns left by one; the head
                // wraps around to the tail.
                if (index_inc == cmd.len)
                    value_next = head_val;
                else if (index_inc < cmd.len)
                    value_next = right_val;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// Positional list engine: push front, append, insert, update and delete each act on the cell row
// at the transfer, and their single result appears in the output register in the cycle after it.
// A dump blocks requests until its last element is out, emitting one element per cycle when the
// output register is free, read from the rotating row's head; throughput is one request
// per cycle otherwise, bounded by the output register. After reset the list is empty and
// the output register holds nothing; the element cells themselves are not cleared.
module positional_list_engine_core (
    input  logic            clk,
    input  logic            rst_n,
    ple_req_if.sink         req,
    ple_res_if.source       res
);

    localparam int CAP = ple_pkg::CAPACITY;

    // Controller state. The dump counter walks the element indexes; the length
    // register is the only list state that reset clears.
    ple_pkg::ple_state_t          state_reg, state_next;
    logic [ple_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [ple_pkg::IDX_W-1:0]    cnt_reg, cnt_next;

    // Output register: parts the result channel from the request side so that
    // a new request is taken in the same cycle that the old result leaves.
    logic                         out_valid_reg, out_valid_next;
    ple_pkg::data_t               out_value_reg, out_value_next;
    logic [ple_pkg::OIDX_W-1:0]   out_index_reg, out_index_next;
    ple_pkg::status_t             out_status_reg, out_status_next;
    logic                         out_last_reg, out_last_next;
    logic [ple_pkg::OLEN_W-1:0]   out_len_reg, out_len_next;

    ple_pkg::cell_cmd_t           cmd;
    ple_pkg::data_t               cell_val [CAP];

    logic                         slot_free;
    logic                         accept;
    logic                         dump_step;
    logic                         dump_last;
    logic                         in_range;
    logic                         is_full;
    logic [ple_pkg::POS_W-1:0]    len_wide;
    logic [ple_pkg::LEN_W-1:0]    ins_clamped;

    assign slot_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == ple_pkg::S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign dump_step = (state_reg == ple_pkg::S_DUMP) && slot_free;
    assign dump_last = (ple_pkg::LEN_W'(cnt_reg) + 1'b1) == len_reg;

    assign len_wide    = ple_pkg::POS_W'(len_reg);
    assign in_range    = req.position < len_wide;
    assign is_full     = len_reg == ple_pkg::LEN_W'(CAP);
    // An insert beyond the end lands at the end.
    assign ins_clamped = (req.position > len_wide) ? len_reg
                                                   : ple_pkg::LEN_W'(req.position);

    // The cell row. Each cell sees both neighbors and the head of the row.
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        ple_pkg::data_t left_val;
        ple_pkg::data_t right_val;

        if (i == 0)
        begin : g_first
            assign left_val = cell_val[i];
        end
        else
        begin : g_inner_left
            assign left_val = cell_val[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_inner_right
            assign right_val = cell_val[i+1];
        end

        ple_cell u_cell (
            .clk       (clk),
            .index     (ple_pkg::LEN_W'(i)),
            .cmd       (cmd),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_val[0]),
            .value     (cell_val[i])
        );
    end

    // Next state, cell command and result register loading.
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_len_next    = out_len_reg;

        cmd.op    = ple_pkg::OP_HOLD;
        cmd.pos   = '0;
        cmd.len   = len_reg;
        cmd.value = req.item_value;

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_index_next  = '0;
                    out_status_next = ple_pkg::ST_OK;
                    out_last_next   = 1'b1;

                    case (req.req_type)
                        ple_pkg::REQ_PUSH_FRONT,
                        ple_pkg::REQ_APPEND,
                        ple_pkg::REQ_INSERT:
                        begin
                            if (is_full)
                            begin
                                out_status_next = ple_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op   = ple_pkg::OP_INSERT;
                                len_next = len_reg + 1'b1;
                                if (req.req_type == ple_pkg::REQ_PUSH_FRONT)
                                    cmd.pos = '0;
                                else if (req.req_type == ple_pkg::REQ_APPEND)
                                    cmd.pos = len_reg;
                                else
                                    cmd.pos = ins_clamped;
                            end
                        end
                        ple_pkg::REQ_UPDATE:
                        begin
                            if (in_range)
                            begin
                                cmd.op  = ple_pkg::OP_WRITE;
                                cmd.pos = ple_pkg::LEN_W'(req.position);
                            end
                            else
                            begin
                                out_status_next = ple_pkg::ST_BADPOS;
                            end
                        end
                        ple_pkg::REQ_DELETE:
                        begin
                            if (in_range)
                            begin
                                cmd.op   = ple_pkg::OP_DELETE;
                                cmd.pos  = ple_pkg::LEN_W'(req.position);
                                len_next = len_reg - 1'b1;
                            end
                            else
                            begin
                                out_status_next = ple_pkg::ST_BADPOS;
                            end
                        end
                        ple_pkg::REQ_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                out_status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // Elements follow one per cycle from the dump state while the output register is free.
                                out_valid_next = 1'b0;
                                cnt_next       = '0;
                                state_next     = ple_pkg::S_DUMP;
                            end
                        end
                        default:
                        begin
                            // Unused request codes leave the list alone.
                            out_status_next = ple_pkg::ST_OK;
                        end
                    endcase

                    out_len_next = ple_pkg::OLEN_W'(len_next);
                end
            end
            ple_pkg::S_DUMP:
            begin
                if (dump_step)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_val[0];
                    out_index_next  = ple_pkg::OIDX_W'(cnt_reg);
                    out_status_next = ple_pkg::ST_OK;
                    out_last_next   = dump_last;
                    out_len_next    = ple_pkg::OLEN_W'(len_reg);
                    cmd.op          = ple_pkg::OP_ROTATE;
                    cnt_next        = cnt_reg + 1'b1;
                    if (dump_last)
                        state_next = ple_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_len_reg    <= out_len_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.out_value   = out_value_reg;
    assign res.out_index   = out_index_reg;
    assign res.status      = out_status_reg;
    assign res.last        = out_last_reg;
    assign res.list_length = out_len_reg;

    // The list never grows past its capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= ple_pkg::LEN_W'(CAP))
        else $error("list length above capacity");

    // While a dump runs, the counter stays inside the list.
    a_dump_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ple_pkg::S_DUMP) |-> (ple_pkg::LEN_W'(cnt_reg) < len_reg))
        else $error("dump counter beyond list length");

    // The final element of a dump returns the controller to idle and marks last.
    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (dump_step && dump_last) |=> (state_reg == ple_pkg::S_IDLE) && res.valid && res.last)
        else $error("dump did not end on its last element");

    // The length does not change while a dump is in progress.
    a_dump_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ple_pkg::S_DUMP) |=> $stable(len_reg))
        else $error("length changed during dump");

endmodule
